// File: rtl/lbml_pkg.sv
// Shared types and constants for the leaky-bucket message limiter.
package lbml_pkg;

  localparam int unsigned MS_PER_SECOND = 1000;
  localparam logic [31:0] MS_MAX = 32'hFFFF_FFFF;

  // Register indexes of the configuration port.
  localparam logic [1:0] REG_RATE  = 2'd0;
  localparam logic [1:0] REG_BURST = 2'd1;

  localparam logic [15:0] RATE_RESET  = 16'd1;
  localparam logic [15:0] BURST_RESET = 16'd5;

  // Drain values are kept saturated at this value; any level is below it.
  localparam logic [16:0] DRAIN_SAT = 17'h1_0000;

  // Reciprocal of 1000 scaled by 2**26, exact for all 16-bit rates.
  localparam logic [16:0] RECIP_1000 = 17'd67109;
  localparam int unsigned RECIP_SHIFT = 26;

  // A product ms * rate at or above 65536 * 1000 gives a saturated drain.
  localparam logic [47:0] DRAIN_LIMIT = 48'd65536000;
  // Reciprocal of 1000 scaled by 2**36, exact for products below DRAIN_LIMIT.
  localparam logic [26:0] RECIP_DRAIN = 27'd68719477;
  localparam int unsigned RECIP_DRAIN_SHIFT = 36;

  // Input action codes.
  localparam logic ACT_TICK    = 1'b0;
  localparam logic ACT_REQUEST = 1'b1;

  typedef struct packed {
    logic        action;
    logic [15:0] cost;
  } in_t;

  typedef struct packed {
    logic        limited;
    logic [15:0] level_after;
  } out_t;

  // Status and results of the drain rescale unit.
  typedef struct packed {
    logic        busy;
    logic        load;
    logic [16:0] quo;
    logic [9:0]  rem;
    logic [6:0]  rate_q;
    logic [9:0]  rate_r;
  } rescale_t;

endpackage

// File: rtl/lbml_rescale.sv
// Recomputes the pending drain (quotient and remainder of ms * rate / 1000) after a rate change.
module lbml_rescale
  import lbml_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [15:0] rate,
  input  logic [31:0] elapsed_ms,
  output rescale_t    status
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_MUL   = 2'd1;
  localparam logic [1:0] ST_RECIP = 2'd2;
  localparam logic [1:0] ST_REM   = 2'd3;

  logic [1:0]  state;
  logic        done;
  logic [47:0] prod;
  logic [9:0]  rem;
  logic [16:0] quo;
  logic [6:0]  rate_q;
  logic [9:0]  rate_r;

  logic [32:0] recip_prod;
  logic        over;
  logic [51:0] quo_prod;
  logic [25:0] quo_k;
  logic [16:0] rate_q_k;

  assign recip_prod = 33'(rate) * 33'(RECIP_1000);
  // Products past the limit only have to give a drain that empties any bucket.
  assign over       = (prod >= DRAIN_LIMIT);
  assign quo_prod   = 52'(prod[25:0]) * 52'(RECIP_DRAIN);
  assign quo_k      = 26'(quo[15:0]) * 26'(MS_PER_SECOND);
  assign rate_q_k   = 17'(rate_q) * 17'(MS_PER_SECOND);

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      done   <= 1'b0;
      rate_q <= 7'(RATE_RESET / MS_PER_SECOND);
      rate_r <= 10'(RATE_RESET % MS_PER_SECOND);
    end else begin
      done <= (state == ST_REM);
      case (state)
        ST_IDLE: begin
          if (start) begin
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          rate_q <= recip_prod[32:RECIP_SHIFT];
          state  <= ST_RECIP;
        end
        ST_RECIP: begin
          state <= ST_REM;
        end
        ST_REM: begin
          rate_r <= 10'(17'(rate) - rate_q_k);
          state  <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_MUL: begin
        prod <= 48'(elapsed_ms) * 48'(rate);
      end
      ST_RECIP: begin
        quo <= over ? DRAIN_SAT : {1'b0, quo_prod[RECIP_DRAIN_SHIFT +: 16]};
      end
      ST_REM: begin
        rem <= quo[16] ? 10'd0 : 10'(prod[25:0] - quo_k);
      end
      default: ;
    endcase
  end

  assign status.busy   = (state != ST_IDLE) || done;
  assign status.load   = done;
  assign status.quo    = quo;
  assign status.rem    = rem;
  assign status.rate_q = rate_q;
  assign status.rate_r = rate_r;

endmodule

// File: rtl/lbml_core.sv
// Bucket state, per-item update and the result register.
module lbml_core
  import lbml_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  in_t         item,
  input  logic [15:0] burst,
  input  rescale_t    rs,
  input  logic        out_taken,
  output logic [31:0] elapsed_ms,
  output logic        out_valid,
  output out_t        out_data
);

  logic [16:0] drain;
  logic [9:0]  drain_rem;
  logic [15:0] level;

  logic [10:0] rem_sum;
  logic        carry;
  logic [17:0] drain_sum;
  logic [15:0] level_mid;
  logic [16:0] level_sum;
  logic        limited;

  // Tick: advance the running quotient and remainder by rate / 1000.
  assign rem_sum   = 11'(drain_rem) + 11'(rs.rate_r);
  assign carry     = (rem_sum >= 11'(MS_PER_SECOND));
  assign drain_sum = 18'(drain) + 18'(rs.rate_q) + 18'(carry);

  // Request: drain first, then try to admit.
  assign level_mid = (drain >= {1'b0, level}) ? 16'd0 : 16'(level - drain[15:0]);
  assign level_sum = 17'(level_mid) + 17'(item.cost);
  assign limited   = (level_sum > {1'b0, burst});

  always_ff @(posedge clk) begin
    if (rst) begin
      elapsed_ms <= '0;
      drain      <= '0;
      drain_rem  <= '0;
      level      <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (accept && item.action == ACT_REQUEST) begin
        out_valid <= 1'b1;
      end else if (out_taken) begin
        out_valid <= 1'b0;
      end
      if (rs.load) begin
        drain     <= rs.quo;
        drain_rem <= rs.rem;
      end else if (accept && item.action == ACT_TICK) begin
        if (elapsed_ms != MS_MAX) begin
          elapsed_ms <= elapsed_ms + 32'd1;
          drain_rem  <= carry ? 10'(rem_sum - 11'(MS_PER_SECOND)) : rem_sum[9:0];
          drain      <= (drain_sum >= 18'(DRAIN_SAT)) ? DRAIN_SAT : drain_sum[16:0];
        end
      end else if (accept && item.action == ACT_REQUEST) begin
        if (drain != '0) begin
          elapsed_ms <= '0;
          drain      <= '0;
          drain_rem  <= '0;
        end
        level <= limited ? level_mid : level_sum[15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && item.action == ACT_REQUEST) begin
      out_data.limited     <= limited;
      out_data.level_after <= limited ? level_mid : level_sum[15:0];
    end
  end

endmodule

// File: rtl/leaky_bucket_message_limiter_unit.sv
// Top level of the leaky-bucket message limiter: configuration registers and handshakes.
//
// Usage: items arrive on in_valid/in_data and are taken at an edge where in_valid
// is high and in_stall is low. A tick item advances the millisecond counter and
// gives no result; a request item gives one result on out_valid/out_data,
// registered in the cycle after the request is taken. One item is taken per cycle
// when no register write or rescale is under way and the result register is free
// or being emptied in the same cycle. The drain owed for elapsed time is kept as a
// running quotient and remainder of ms * rate / 1000, so a request needs only a
// compare and an add. Writing tokens_per_second starts a rescale of that quotient:
// one multiply, a reciprocal multiply and a remainder step. in_stall is high from
// the write until the rescaled drain is loaded. Writing burst_tokens takes effect
// at once. Reset (rst, synchronous) sets the rate to 1, the burst to 5, and clears
// the counter, the bucket level and the result valid flag.
// While out_stall holds a waiting result, in_stall is raised and the result holds.
module leaky_bucket_message_limiter_unit
  import lbml_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_t        out_data,
  input  logic        wr_en,
  input  logic [1:0]  wr_index,
  input  logic [15:0] wr_data
);

  logic [15:0] rate;
  logic [15:0] burst;
  logic [31:0] elapsed_ms;
  rescale_t    rs;
  logic        rate_write;
  logic        out_taken;
  logic        accept;

  assign rate_write = wr_en && (wr_index == REG_RATE);
  assign out_taken  = out_valid && !out_stall;
  assign in_stall   = rs.busy || wr_en || (out_valid && out_stall);
  assign accept     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      rate  <= RATE_RESET;
      burst <= BURST_RESET;
    end else if (wr_en) begin
      case (wr_index)
        REG_RATE:  rate  <= wr_data;
        REG_BURST: burst <= wr_data;
        default: ;
      endcase
    end
  end

  lbml_rescale u_rescale (
    .clk        (clk),
    .rst        (rst),
    .start      (rate_write),
    .rate       (rate),
    .elapsed_ms (elapsed_ms),
    .status     (rs)
  );

  lbml_core u_core (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .item       (in_data),
    .burst      (burst),
    .rs         (rs),
    .out_taken  (out_taken),
    .elapsed_ms (elapsed_ms),
    .out_valid  (out_valid),
    .out_data   (out_data)
  );

endmodule

// File: tb/leaky_bucket_message_limiter_unit_tb.sv
// Self-checking testbench for the leaky-bucket limiter: directed and random requests.
module leaky_bucket_message_limiter_unit_tb;
  import lbml_pkg::*;

  // Indexes past the register list; writes to them must change nothing.
  localparam logic [1:0] REG_SPARE_A = 2'd2;
  localparam logic [1:0] REG_SPARE_B = 2'd3;
  localparam int SETTLE_CYCLES = 4;
  localparam int PHASE_ITEMS = 150;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_t         in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_t        out_data;
  logic        wr_en = 1'b0;
  logic [1:0]  wr_index = '0;
  logic [15:0] wr_data = '0;

  // Bucket state as the block should hold it.
  logic [15:0] rate_cfg = RATE_RESET;
  logic [15:0] burst_cfg = BURST_RESET;
  logic [31:0] ms_count = '0;
  logic [15:0] level = '0;

  in_t         pending_items[$];
  out_t        expected_verdicts[$];
  out_t        oldest;
  int unsigned send_idle_pct = 23;
  int unsigned recv_stall_pct = 82;
  int          mismatch_count = 0;

  leaky_bucket_message_limiter_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .wr_en     (wr_en),
    .wr_index  (wr_index),
    .wr_data   (wr_data)
  );

  always #10 clk = ~clk;

  function automatic out_t bucket_request(logic [15:0] tokens);
    logic [47:0] drain;
    logic [16:0] sum;
    out_t        verdict;
    drain = ({16'd0, ms_count} * {32'd0, rate_cfg}) / MS_PER_SECOND;
    // Elapsed time is only consumed when at least one whole token drains.
    if (drain != '0) ms_count = '0;
    if (drain >= {32'd0, level}) level = '0;
    else level = level - drain[15:0];
    sum = {1'b0, level} + {1'b0, tokens};
    verdict.limited = (sum > {1'b0, burst_cfg});
    if (!verdict.limited) level = sum[15:0];
    verdict.level_after = level;
    return verdict;
  endfunction

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        if (in_data.action == ACT_REQUEST) expected_verdicts.push_back(bucket_request(in_data.cost));
        else if (ms_count != MS_MAX) ms_count = ms_count + 1;
      end
      if (!in_valid || !in_stall) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data <= pending_items.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_verdicts.size() == 0) begin
          $error("result with no request outstanding: limited=%0d level_after=%0d",
                 out_data.limited, out_data.level_after);
          mismatch_count++;
        end else begin
          oldest = expected_verdicts.pop_front();
          if (out_data.limited !== oldest.limited) begin
            $error("limited: expected %0d, actual %0d", oldest.limited, out_data.limited);
            mismatch_count++;
          end
          if (out_data.level_after !== oldest.level_after) begin
            $error("level_after: expected %0d, actual %0d",
                   oldest.level_after, out_data.level_after);
            mismatch_count++;
          end
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic write_reg(logic [1:0] index, logic [15:0] value);
    @(posedge clk);
    wr_en <= 1'b1;
    wr_index <= index;
    wr_data <= value;
    @(posedge clk);
    wr_en <= 1'b0;
    case (index)
      REG_RATE:  rate_cfg = value;
      REG_BURST: burst_cfg = value;
      default: ;
    endcase
    // A rate write rescales the owed drain and holds off requests meanwhile.
    @(negedge clk);
    while (in_stall) @(negedge clk);
  endtask

  task automatic wait_idle(int hold);
    @(negedge clk);
    while (pending_items.size() != 0 || in_valid || expected_verdicts.size() != 0)
      @(negedge clk);
    repeat (hold) @(posedge clk);
  endtask

  task automatic queue_request(logic [15:0] tokens);
    pending_items.push_back(in_t'{action: ACT_REQUEST, cost: tokens});
  endtask

  task automatic queue_ticks(int count);
    repeat (count) pending_items.push_back(in_t'{action: ACT_TICK, cost: 16'($urandom)});
  endtask

  function automatic logic [15:0] pick_cost();
    case ($urandom_range(9))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'($urandom);
      default: return 16'($urandom_range(burst_cfg / 4 + 2));
    endcase
  endfunction

  task automatic fill_random(int count);
    int queued;
    int run;
    queued = 0;
    while (queued < count) begin
      if ($urandom_range(9) == 0) begin
        // A run of ticks lets enough time build up for whole tokens to drain.
        run = $urandom_range(60, 2);
        queue_ticks(run);
        queued += run;
      end else if ($urandom_range(2) == 0) begin
        queue_ticks(1);
        queued++;
      end else begin
        queue_request(pick_cost());
        queued++;
      end
    end
  endtask

  initial begin
    int step;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: fill to capacity, overflow, and a fraction of a token kept.
    queue_request(16'd0);
    queue_request(16'd5);
    queue_request(16'd1);
    queue_request(16'hFFFF);
    queue_ticks(1);
    queue_request(16'd0);
    wait_idle(SETTLE_CYCLES);

    write_reg(REG_RATE, 16'hFFFF);
    write_reg(REG_BURST, 16'hFFFF);
    write_reg(REG_SPARE_A, 16'h0000);
    write_reg(REG_SPARE_B, 16'hFFFF);
    // The owed drain empties the bucket, then it fills to the very top.
    queue_request(16'hFFFF);
    queue_request(16'd0);
    queue_request(16'd1);
    queue_ticks(2);
    queue_request(16'd0);
    wait_idle(SETTLE_CYCLES);

    // Capacity below the level and no drain at all.
    write_reg(REG_BURST, 16'd0);
    write_reg(REG_RATE, 16'd0);
    queue_request(16'd0);
    queue_ticks(3);
    queue_request(16'd0);

    for (step = 0; step < 9; step++) begin
      wait_idle(SETTLE_CYCLES);
      case (step / 3)
        0: begin
          send_idle_pct = 23;
          recv_stall_pct = 82;
        end
        1: begin
          send_idle_pct = 82;
          recv_stall_pct = 23;
        end
        default: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
      endcase
      case (step % 5)
        0: begin
          write_reg(REG_RATE, 16'd0);
          write_reg(REG_BURST, 16'($urandom));
        end
        1: begin
          write_reg(REG_RATE, 16'hFFFF);
          write_reg(REG_BURST, 16'hFFFF);
        end
        2: begin
          write_reg(REG_RATE, 16'd1);
          write_reg(REG_BURST, 16'd0);
        end
        3: begin
          write_reg(REG_RATE, 16'($urandom_range(2000, 1)));
          write_reg(REG_BURST, 16'($urandom_range(400)));
        end
        default: begin
          write_reg(REG_RATE, 16'($urandom));
          write_reg(REG_BURST, 16'($urandom));
        end
      endcase
      if (step % 3 == 1) begin
        // Stop sending halfway until every result is back.
        fill_random(PHASE_ITEMS / 2);
        wait_idle(0);
        fill_random(PHASE_ITEMS / 2);
      end else begin
        fill_random(PHASE_ITEMS);
      end
    end

    wait_idle(SETTLE_CYCLES);
    if (mismatch_count == 0) begin
      $display("** leaky_bucket_message_limiter_unit: PASSED **");
    end else begin
      $display("** leaky_bucket_message_limiter_unit: FAILED **");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("** leaky_bucket_message_limiter_unit: FAILED **");
    $finish;
  end

endmodule
